/* rtl/core/blpk_pkg.sv */
// Shared constants and types for the braille line dot-row packer.
package blpk_pkg;

	localparam int CODE_W = 8;
	localparam int CELL_W = 6;
	localparam int BYTE_W = 8;
	localparam int ROW_W = 2;
	localparam int ROWS = 3;
	localparam int LW_W = 5;
	localparam int MAX_GROUPS_DEF = 16;
	localparam int ENTRY_W = ROWS * BYTE_W;

	localparam logic [LW_W-1:0] LINE_WIDTH_RST = 5'd7;
	localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
	localparam logic [ROW_W-1:0] ROW_MID = 2'd1;
	localparam logic [ROW_W-1:0] ROW_LAST = 2'd2;

	typedef struct packed {
		logic [CELL_W-1:0] dots;
		logic emit;
		logic [LW_W-1:0] width;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

endpackage

/* rtl/core/braille_line_dot_row_packer.sv */
// Braille line dot-row packer: one cell a cycle in, a line of packed dot-row bytes out.
// A cell word is taken at each clock edge with start high and busy low, one per cycle
// while the two-entry command queue has room. The word that closes a line (4 x line_width
// cells) holds the back end while it emits one byte per cycle: all bytes of dot row 0,
// then row 1, then row 2, each registered through the store read stage and the byte
// stage before it reaches the outputs. Busy rises once the queue fills behind it. Results
// are shown for one cycle on result_valid and cannot be held off. The user must see that
// line_width is written through cfg_we/cfg_wdata only while the block is idle; the block
// does not enforce this. 0 acts as 1 and values above MAX_GROUPS act as MAX_GROUPS.
module braille_line_dot_row_packer #(
	parameter int MAX_GROUPS = blpk_pkg::MAX_GROUPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [blpk_pkg::LW_W-1:0]     cfg_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic [blpk_pkg::CODE_W-1:0]   cell_code,
	output logic                          result_valid,
	output logic [blpk_pkg::BYTE_W-1:0]   packed_byte,
	output logic [blpk_pkg::ROW_W-1:0]    dot_row,
	output logic                          last_of_line
);
	import blpk_pkg::*;

	localparam int CNT_W = $clog2(4 * MAX_GROUPS);
	localparam int Q_W = CMD_W + CNT_W;

	logic             accept;
	cmd_t             front_cmd;
	logic [CNT_W-1:0] front_idx;
	logic [Q_W-1:0]   q_rdata;
	logic             q_full;
	logic             q_empty;
	logic             back_pop;
	cmd_t             back_cmd;
	logic [CNT_W-1:0] back_idx;

	assign busy = q_full;
	assign accept = start && !q_full;

	blpk_front #(.MAX_GROUPS(MAX_GROUPS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.cell_code (cell_code),
		.cmd       (front_cmd),
		.idx       (front_idx)
	);

	blpk_cmd_fifo #(.WIDTH(Q_W)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  ({front_cmd, front_idx}),
		.pop    (back_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign back_cmd = q_rdata[Q_W-1:CNT_W];
	assign back_idx = q_rdata[CNT_W-1:0];

	blpk_back #(.MAX_GROUPS(MAX_GROUPS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (!q_empty),
		.cmd          (back_cmd),
		.idx          (back_idx),
		.pop          (back_pop),
		.result_valid (result_valid),
		.packed_byte  (packed_byte),
		.dot_row      (dot_row),
		.last_of_line (last_of_line)
	);

endmodule

/* rtl/core/blpk_front.sv */
// Front end: width register, cell counter and command building for each cell.
module blpk_front #(
	parameter int MAX_GROUPS = blpk_pkg::MAX_GROUPS_DEF,
	localparam int CNT_W = $clog2(4 * MAX_GROUPS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [blpk_pkg::LW_W-1:0] cfg_wdata,
	input  logic                      accept,
	input  logic [blpk_pkg::CODE_W-1:0] cell_code,
	output blpk_pkg::cmd_t            cmd,
	output logic [CNT_W-1:0]          idx
);
	import blpk_pkg::*;

	localparam int CMP_W = (CNT_W + 1 > LW_W + 2) ? CNT_W + 1 : LW_W + 2;
	localparam logic [LW_W-1:0] MAX_LW = LW_W'(MAX_GROUPS);
	localparam logic [CMP_W-1:0] CELLS_MAX = CMP_W'(4 * MAX_GROUPS);

	logic [LW_W-1:0]  width_q;
	logic [LW_W-1:0]  eff_width;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W:0]   cnt_nxt;
	logic [CMP_W-1:0] cnt_cmp;
	logic [CMP_W-1:0] total_cmp;
	logic             line_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= LINE_WIDTH_RST;
		end else if (cfg_we) begin
			width_q <= cfg_wdata;
		end
	end

	always_comb begin
		eff_width = width_q;
		if (width_q == '0) begin
			eff_width = LW_W'(1);
		end else if (width_q > MAX_LW) begin
			eff_width = MAX_LW;
		end
	end

	assign cnt_nxt = {1'b0, cnt_q} + (CNT_W + 1)'(1);
	assign cnt_cmp = CMP_W'(cnt_nxt);
	assign total_cmp = CMP_W'({eff_width, 2'b00});
	// A width lowered mid-line can leave the count past the new total; close the line then too.
	assign line_done = (cnt_cmp >= total_cmp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= line_done ? '0 : cnt_nxt[CNT_W-1:0];
		end
	end

	assign cmd.dots = cell_code[CELL_W-1:0];
	assign cmd.emit = line_done;
	assign cmd.width = eff_width;
	assign idx = cnt_q;

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(cnt_q) < CELLS_MAX)
		else $error("cell count left the store range");

endmodule

/* rtl/core/blpk_cmd_fifo.sv */
// Two-entry command queue between the front end and the back end.
module blpk_cmd_fifo #(
	parameter int WIDTH = blpk_pkg::CMD_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	import blpk_pkg::*;

	localparam int DEPTH = 2;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full = (cnt_q == 2'(DEPTH));
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("command popped from an empty queue");

endmodule

/* rtl/core/blpk_back.sv */
// Back end: group store, cell writes and the three-row byte emission.
module blpk_back #(
	parameter int MAX_GROUPS = blpk_pkg::MAX_GROUPS_DEF,
	localparam int CNT_W = $clog2(4 * MAX_GROUPS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  blpk_pkg::cmd_t              cmd,
	input  logic [CNT_W-1:0]            idx,
	output logic                        pop,
	output logic                        result_valid,
	output logic [blpk_pkg::BYTE_W-1:0] packed_byte,
	output logic [blpk_pkg::ROW_W-1:0]  dot_row,
	output logic                        last_of_line
);
	import blpk_pkg::*;

	localparam int GRP_W = (CNT_W > 3) ? CNT_W - 2 : 1;

	// Each entry holds four cells already arranged as the three output bytes.
	logic [ENTRY_W-1:0] mem_q [MAX_GROUPS];

	logic [GRP_W-1:0]  wr_grp;
	logic [1:0]        lane;
	logic              emit_q;
	logic [ROW_W-1:0]  row_q;
	logic [GRP_W-1:0]  grp_q;
	logic [GRP_W-1:0]  glast_q;
	logic              grp_end;

	logic               valid_s1;
	logic [ROW_W-1:0]   row_s1;
	logic               last_s1;
	logic [ENTRY_W-1:0] rd_s1;

	logic              valid_s2;
	logic [BYTE_W-1:0] byte_s2;
	logic [ROW_W-1:0]  row_s2;
	logic              last_s2;

	assign pop = cmd_valid && !emit_q;
	assign wr_grp = GRP_W'({1'b0, idx} >> 2);
	assign lane = idx[1:0];
	assign grp_end = (grp_q == glast_q);

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int r = 0; r < ROWS; r++) begin
				mem_q[wr_grp][r * BYTE_W + 6 - 2 * int'(lane) +: 2] <=
					cmd.dots[CELL_W - 1 - 2 * r -: 2];
			end
		end
		rd_s1 <= mem_q[grp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
			row_q <= ROW_FIRST;
			grp_q <= '0;
			glast_q <= '0;
		end else if (pop && cmd.emit) begin
			emit_q <= 1'b1;
			row_q <= ROW_FIRST;
			grp_q <= '0;
			glast_q <= GRP_W'(cmd.width - LW_W'(1));
		end else if (emit_q) begin
			if (grp_end) begin
				grp_q <= '0;
				if (row_q == ROW_LAST) begin
					emit_q <= 1'b0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				grp_q <= grp_q + GRP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			valid_s1 <= emit_q;
			last_s1 <= emit_q && (row_q == ROW_LAST) && grp_end;
			valid_s2 <= valid_s1;
			last_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= row_q;
		row_s2 <= row_s1;
		unique case (row_s1)
			ROW_FIRST: byte_s2 <= rd_s1[0 +: BYTE_W];
			ROW_MID:   byte_s2 <= rd_s1[BYTE_W +: BYTE_W];
			default:   byte_s2 <= rd_s1[2 * BYTE_W +: BYTE_W];
		endcase
	end

	assign result_valid = valid_s2;
	assign packed_byte = byte_s2;
	assign dot_row = row_s2;
	assign last_of_line = last_s2;

	a_last_on_bottom_row: assert property (@(posedge clk) disable iff (!arst_n)
		last_of_line |-> (result_valid && dot_row == ROW_LAST))
		else $error("line end flagged off the bottom dot row");

	a_read_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> result_valid)
		else $error("store read did not reach the result port");

	a_no_pop_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q |-> !pop)
		else $error("command taken while a line is being emitted");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the braille line dot-row packer.
`timescale 1ns / 100ps

module tb_top;
	import blpk_pkg::*;

	localparam int CELLS_MAX = 4 * MAX_GROUPS_DEF;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_CELLS = 220;

	typedef struct {
		logic [BYTE_W-1:0] value;
		logic [ROW_W-1:0] row;
		logic last;
	} dot_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [LW_W-1:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic [CODE_W-1:0] cell_code = '0;
	logic result_valid;
	logic [BYTE_W-1:0] packed_byte;
	logic [ROW_W-1:0] dot_row;
	logic last_of_line;

	// Our own copy of the line state.
	logic [LW_W-1:0] width_now = LINE_WIDTH_RST;
	logic [CELL_W-1:0] line_cells [CELLS_MAX];
	int unsigned cells_held = 0;
	dot_byte_t pending_bytes [$];

	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	int unsigned cells_sent = 0;
	int unsigned bytes_checked = 0;
	int unsigned lines_packed = 0;
	logic [31:0] widths_written = '0;

	braille_line_dot_row_packer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.cell_code(cell_code),
		.result_valid(result_valid),
		.packed_byte(packed_byte),
		.dot_row(dot_row),
		.last_of_line(last_of_line)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int clamp_width(input logic [LW_W-1:0] w);
		int g;
		g = w;
		if (g == 0)
			g = 1;
		if (g > MAX_GROUPS_DEF)
			g = MAX_GROUPS_DEF;
		return g;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH %0d at cycle %0d: %s", mismatches, cycles, msg);
	endtask

	// Stores one cell; when the line is full, queues its packed bytes row by row.
	task automatic store_cell(input logic [CODE_W-1:0] code);
		int groups;
		int shift;
		int pair;
		dot_byte_t b;
		groups = clamp_width(width_now);
		if (cells_held < CELLS_MAX)
			line_cells[cells_held] = code[CELL_W-1:0];
		cells_held++;
		if (cells_held >= 4 * groups) begin
			for (int r = 0; r < ROWS; r++) begin
				shift = 4 - 2 * r;
				for (int g = 0; g < groups; g++) begin
					b.value = '0;
					for (int k = 0; k < 4; k++) begin
						pair = (line_cells[4 * g + k] >> shift) & 3;
						b.value = {b.value[BYTE_W-3:0], pair[1:0]};
					end
					b.row = r[ROW_W-1:0];
					b.last = (b.row == ROW_LAST) && (g == groups - 1);
					pending_bytes.push_back(b);
				end
			end
			cells_held = 0;
			lines_packed++;
		end
	endtask

	task automatic check_byte();
		dot_byte_t want;
		if (pending_bytes.size() == 0) begin
			report_mismatch($sformatf("unexpected byte %02h row %0d", packed_byte, dot_row));
		end else begin
			want = pending_bytes.pop_front();
			bytes_checked++;
			if (packed_byte !== want.value)
				report_mismatch($sformatf("packed_byte %02h, want %02h", packed_byte, want.value));
			if (dot_row !== want.row)
				report_mismatch($sformatf("dot_row %0d, want %0d", dot_row, want.row));
			if (last_of_line !== want.last)
				report_mismatch($sformatf("last_of_line %0b, want %0b", last_of_line, want.last));
		end
	endtask

	// Values sampled here are the ones present before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				width_now = cfg_wdata;
			if (start && !busy)
				store_cell(cell_code);
			if (result_valid)
				check_byte();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d bytes outstanding", cycles,
				pending_bytes.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Leaves start high so that a following word can go out on the next edge.
	task automatic send_cell(input logic [CODE_W-1:0] code);
		start <= 1'b1;
		cell_code <= code;
		do
			@(posedge clk);
		while (busy);
		cells_sent++;
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Waits for every expected byte, then for the back end to settle.
	task automatic drain();
		idle_cycles(1);
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_line_width(input logic [LW_W-1:0] w);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		widths_written[w] = 1'b1;
	endtask

	task automatic send_random_cells(input int n, input bit steady);
		int left;
		int run;
		left = n;
		while (left > 0) begin
			run = $urandom_range(1, 12);
			if (run > left)
				run = left;
			repeat (run) send_cell(CODE_W'($urandom_range(0, 255)));
			left -= run;
			if (!steady && $urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 6));
		end
	endtask

	task automatic test_reset_width();
		send_random_cells(4 * LINE_WIDTH_RST, 1'b0);
		drain();
	endtask

	// Dot extremes, ignored top bits and each dot row alone.
	task automatic test_narrowest_line();
		set_line_width(LW_W'(1));
		send_cell(8'h00);
		send_cell(8'hFF);
		send_cell(8'h3F);
		send_cell(8'hC0);
		send_cell(8'h30);
		send_cell(8'h0C);
		send_cell(8'h03);
		send_cell(8'h2A);
		drain();
	endtask

	task automatic test_zero_width();
		set_line_width(LW_W'(0));
		send_cell(8'h15);
		send_cell(8'h2A);
		send_cell(8'h3F);
		send_cell(8'h40);
		drain();
	endtask

	// Five cells held at width 2; the next one at width 1 already overfills the line.
	task automatic test_width_shrink_midline();
		set_line_width(LW_W'(2));
		send_random_cells(5, 1'b1);
		drain();
		set_line_width(LW_W'(1));
		send_cell(8'h21);
		drain();
	endtask

	task automatic test_width_grow_midline();
		set_line_width(LW_W'(1));
		send_random_cells(2, 1'b1);
		drain();
		set_line_width(LW_W'(2));
		send_random_cells(6, 1'b0);
		drain();
	endtask

	// Mostly whole lines at small widths, with stray partial lines left across
	// width changes; the widest settings come first.
	task automatic test_random_lines();
		int target;
		int phase;
		int groups;
		int n;
		logic [LW_W-1:0] w;
		target = cells_sent + RANDOM_CELLS;
		phase = 0;
		while (cells_sent < target) begin
			if (phase == 0)
				w = LW_W'(MAX_GROUPS_DEF);
			else if (phase == 1)
				w = '1;
			else if ($urandom_range(0, 9) < 6)
				w = LW_W'($urandom_range(1, 4));
			else
				w = LW_W'($urandom_range(0, 31));
			set_line_width(w);
			groups = clamp_width(w);
			n = 4 * groups * ((groups > 8) ? 1 : $urandom_range(1, 3));
			if ($urandom_range(0, 3) == 0)
				n += $urandom_range(1, 4 * groups - 1);
			send_random_cells(n, $urandom_range(0, 3) == 0);
			drain();
			phase++;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_width();
		test_narrowest_line();
		test_zero_width();
		test_width_shrink_midline();
		test_width_grow_midline();
		test_random_lines();
		drain();
		if (pending_bytes.size() != 0)
			report_mismatch($sformatf("%0d bytes never arrived", pending_bytes.size()));
		$display("Sent %0d cells and checked %0d packed bytes in %0d lines.", cells_sent,
			bytes_checked, lines_packed);
		$display("Used %0d distinct line_width values, %0d mismatches.",
			$countones(widths_written), mismatches);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
